[hw/rtl/bts_pkg.sv]
// Shared types, codes and arithmetic helpers for the bilinear texture sampler.
`default_nettype none

package bts_pkg;

    localparam logic [1:0] FUNC_STORE  = 2'd0;
    localparam logic [1:0] FUNC_LOAD   = 2'd1;
    localparam logic [1:0] FUNC_SAMPLE = 2'd2;

    localparam logic REG_WIDTH_IDX  = 1'b0;
    localparam logic REG_HEIGHT_IDX = 1'b1;

    localparam int COORD_ONE = 65536;

    typedef struct packed {
        logic [1:0]         func;
        logic [7:0]         tex_x;
        logic [7:0]         tex_y;
        logic [15:0]        texel_red;
        logic [15:0]        texel_green;
        logic [15:0]        texel_blue;
        logic [15:0]        texel_alpha;
        logic signed [23:0] u_coord;
        logic signed [23:0] v_coord;
        logic               wrap_mode;
    } in_item_t;

    typedef struct packed {
        logic [15:0] out_red;
        logic [15:0] out_green;
        logic [15:0] out_blue;
        logic [15:0] out_alpha;
    } out_item_t;

    typedef struct packed {
        logic        result;
        logic        inrange;
        logic        x0b;
        logic        x1b;
        logic        y0b;
        logic        y1b;
        logic [15:0] fx;
        logic [15:0] fy;
    } sel_ctl_t;

    function automatic logic [16:0] fold_coord(input logic signed [23:0] c, input logic wrap);
        logic [16:0] r;
        if (wrap) begin
            r = {1'b0, c[15:0]};
        end else if (c < 24'sd0) begin
            r = 17'd0;
        end else if (c > 24'sd65536) begin
            r = 17'(COORD_ONE);
        end else begin
            r = c[16:0];
        end
        return r;
    endfunction

    function automatic logic [15:0] lerp16(input logic [15:0] a, input logic [15:0] b,
                                           input logic [15:0] f);
        logic [32:0] s;
        s = 33'(a) * 33'(17'(COORD_ONE) - 17'(f)) + 33'(b) * 33'(f);
        return s[31:16];
    endfunction

endpackage

`default_nettype wire

[hw/rtl/bilinear_texture_sampler.sv]
// Top level of the bilinear texture sampler: coordinate stages, texel banks and blend.
//
// Items arrive on the s_ channel (valid/ready) as one in_item_t. A store writes one
// texel, a load returns one texel and a sample returns the bilinear blend of four
// texels; stores and unknown functions produce no transfer on the m_ channel.
// The image size is set through the APB port (width at 0x0, height at 0x4) and
// resets to 256 by 256.
// Items pass s1, s2, s3, s4 and the output register. Unless held, one item is accepted
// every cycle: the store is split into four banks by row and column parity, so the
// four neighbours of a sample are read in a single cycle, one from each bank.
// Stores write at the same stage where reads are issued, so items take effect in
// order without forwarding.
// Reset clears all valid flags; the texel memory is not cleared and must be written
// before it is read. When the receiver holds m_ready low with a result waiting, the
// whole pipeline holds and s_ready falls.
`default_nettype none

module bilinear_texture_sampler #(
    parameter int MAX_DIM = 256
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire bts_pkg::in_item_t   s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output bts_pkg::out_item_t       m_data,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    import bts_pkg::*;

    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int CW = ($clog2(MAX_DIM) > 0) ? $clog2(MAX_DIM) : 1;
    localparam int HW = (CW > 1) ? CW - 1 : 1;
    localparam int AB = 2 * HW;
    localparam int SW = DW + 17;

    logic              en;
    logic [DW-1:0]     w_eff;
    logic [DW-1:0]     h_eff;

    logic              s1_valid_reg;
    in_item_t          s1_item_reg;
    logic [16:0]       u_fold;
    logic [16:0]       v_fold;

    logic              s2_valid_reg;
    logic [1:0]        s2_func_reg;
    logic [7:0]        s2_tx_reg;
    logic [7:0]        s2_ty_reg;
    logic [63:0]       s2_texel_reg;
    logic [SW-1:0]     s2_su_reg;
    logic [SW-1:0]     s2_sv_reg;

    logic [DW-1:0]     wm1;
    logic [DW-1:0]     hm1;
    logic [DW:0]       xi;
    logic [DW:0]       yi;
    logic [DW-1:0]     xs0;
    logic [DW-1:0]     ys0;
    logic [DW-1:0]     xs1;
    logic [DW-1:0]     ys1;
    logic [CW-1:0]     x0;
    logic [CW-1:0]     x1;
    logic [CW-1:0]     y0;
    logic [CW-1:0]     y1;
    logic [CW-1:0]     tx;
    logic [CW-1:0]     ty;
    logic              inrange;
    logic              is_sample;
    sel_ctl_t          ctl_next;
    sel_ctl_t          s3_ctl_reg;
    logic              store_we;
    logic [AB-1:0]     waddr;
    logic [3:0][AB-1:0] raddr;
    logic [3:0][63:0]  bank_rdata;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    bts_cfg #(
        .MAX_DIM (MAX_DIM),
        .DW      (DW)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .w_eff   (w_eff),
        .h_eff   (h_eff)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_ctl_reg   <= '0;
        end else if (en) begin
            s1_valid_reg <= s_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_ctl_reg   <= ctl_next;
        end
    end

    assign u_fold = fold_coord(s1_item_reg.u_coord, s1_item_reg.wrap_mode);
    assign v_fold = fold_coord(s1_item_reg.v_coord, s1_item_reg.wrap_mode);

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_item_reg  <= s_data;
            s2_func_reg  <= s1_item_reg.func;
            s2_tx_reg    <= s1_item_reg.tex_x;
            s2_ty_reg    <= s1_item_reg.tex_y;
            s2_texel_reg <= {s1_item_reg.texel_alpha, s1_item_reg.texel_blue,
                             s1_item_reg.texel_green, s1_item_reg.texel_red};
            s2_su_reg    <= SW'(w_eff) * SW'(u_fold);
            s2_sv_reg    <= SW'(h_eff) * SW'(v_fold);
        end
    end

    always_comb begin
        wm1 = w_eff - DW'(1);
        hm1 = h_eff - DW'(1);
        xi  = s2_su_reg[SW-1:16];
        yi  = s2_sv_reg[SW-1:16];
        xs0 = (xi > {1'b0, wm1}) ? wm1 : xi[DW-1:0];
        ys0 = (yi > {1'b0, hm1}) ? hm1 : yi[DW-1:0];
        xs1 = (xs0 + DW'(1) > wm1) ? wm1 : xs0 + DW'(1);
        ys1 = (ys0 + DW'(1) > hm1) ? hm1 : ys0 + DW'(1);
        tx  = CW'(s2_tx_reg);
        ty  = CW'(s2_ty_reg);
        inrange   = (32'(s2_tx_reg) < 32'(MAX_DIM)) && (32'(s2_ty_reg) < 32'(MAX_DIM));
        is_sample = (s2_func_reg == FUNC_SAMPLE);
        if (is_sample) begin
            x0 = CW'(xs0);
            x1 = CW'(xs1);
            y0 = CW'(ys0);
            y1 = CW'(ys1);
        end else begin
            x0 = tx;
            x1 = tx;
            y0 = ty;
            y1 = ty;
        end
        ctl_next.result  = s2_valid_reg &&
                           (s2_func_reg == FUNC_LOAD || s2_func_reg == FUNC_SAMPLE);
        ctl_next.inrange = is_sample || inrange;
        ctl_next.x0b     = x0[0];
        ctl_next.x1b     = x1[0];
        ctl_next.y0b     = y0[0];
        ctl_next.y1b     = y1[0];
        ctl_next.fx      = is_sample ? s2_su_reg[15:0] : 16'd0;
        ctl_next.fy      = is_sample ? s2_sv_reg[15:0] : 16'd0;
        store_we = en && s2_valid_reg && (s2_func_reg == FUNC_STORE) && inrange;
        waddr    = {HW'(ty >> 1), HW'(tx >> 1)};
        for (int b = 0; b < 4; b++) begin
            raddr[b] = {HW'(((y0[0] == b[1]) ? y0 : y1) >> 1),
                        HW'(((x0[0] == b[0]) ? x0 : x1) >> 1)};
        end
    end

    for (genvar b = 0; b < 4; b++) begin : g_bank
        bts_ram #(
            .WIDTH (64),
            .DEPTH (2 ** AB)
        ) u_bank (
            .aclk  (aclk),
            .we    (store_we && ({ty[0], tx[0]} == 2'(b))),
            .waddr (waddr),
            .wdata (s2_texel_reg),
            .re    (en),
            .raddr (raddr[b]),
            .rdata (bank_rdata[b])
        );
    end

    bts_filter u_filter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .ctl        (s3_ctl_reg),
        .bank_rdata (bank_rdata),
        .m_valid    (m_valid),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire

[hw/rtl/bts_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module bts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16384
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hw/rtl/bts_cfg.sv]
// APB register file holding the image size, with the effective dimensions derived from it.
`default_nettype none

module bts_cfg #(
    parameter int MAX_DIM = 256,
    parameter int DW      = 9
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [DW-1:0]      w_eff,
    output logic [DW-1:0]      h_eff
);
    import bts_pkg::*;

    localparam int EW = (DW > 9) ? DW : 9;

    logic [8:0]    width_reg;
    logic [8:0]    width_next;
    logic [8:0]    height_reg;
    logic [8:0]    height_next;
    logic [EW-1:0] wx;
    logic [EW-1:0] hx;
    logic          wr;

    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (wr) begin
            case (paddr[2])
                REG_WIDTH_IDX:  width_next  = pwdata[8:0];
                REG_HEIGHT_IDX: height_next = pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    assign prdata = (paddr[2] == REG_HEIGHT_IDX) ? {23'd0, height_reg} : {23'd0, width_reg};

    assign wx = EW'(width_reg);
    assign hx = EW'(height_reg);

    always_comb begin
        if (wx == '0) begin
            w_eff = DW'(1);
        end else if (wx > EW'(MAX_DIM)) begin
            w_eff = DW'(MAX_DIM);
        end else begin
            w_eff = DW'(wx);
        end
        if (hx == '0) begin
            h_eff = DW'(1);
        end else if (hx > EW'(MAX_DIM)) begin
            h_eff = DW'(MAX_DIM);
        end else begin
            h_eff = DW'(hx);
        end
    end

endmodule

`default_nettype wire

[hw/rtl/bts_filter.sv]
// Texel selection from the four banks, two-stage bilinear blend and the output register.
`default_nettype none

module bts_filter (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                en,
    input  wire bts_pkg::sel_ctl_t   ctl,
    input  wire logic [3:0][63:0]    bank_rdata,
    output logic                     m_valid,
    output bts_pkg::out_item_t       m_data
);
    import bts_pkg::*;

    logic [63:0]       t00;
    logic [63:0]       t10;
    logic [63:0]       t01;
    logic [63:0]       t11;
    logic [3:0][15:0]  r0_next;
    logic [3:0][15:0]  r1_next;
    logic [3:0][15:0]  r0_reg;
    logic [3:0][15:0]  r1_reg;
    logic [15:0]       fy_reg;
    logic              s4_valid_reg;
    logic [3:0][15:0]  res;
    logic              m_valid_reg;
    out_item_t         m_data_reg;

    always_comb begin
        t00 = bank_rdata[{ctl.y0b, ctl.x0b}];
        t10 = bank_rdata[{ctl.y0b, ctl.x1b}];
        t01 = bank_rdata[{ctl.y1b, ctl.x0b}];
        t11 = bank_rdata[{ctl.y1b, ctl.x1b}];
        if (!ctl.inrange) begin
            t00 = '0;
        end
        for (int k = 0; k < 4; k++) begin
            r0_next[k] = lerp16(t00[16*k +: 16], t10[16*k +: 16], ctl.fx);
            r1_next[k] = lerp16(t01[16*k +: 16], t11[16*k +: 16], ctl.fx);
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            res[k] = lerp16(r0_reg[k], r1_reg[k], fy_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (en) begin
            s4_valid_reg <= ctl.result;
            m_valid_reg  <= s4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r0_reg     <= r0_next;
            r1_reg     <= r1_next;
            fy_reg     <= ctl.fy;
            m_data_reg <= '{out_red: res[0], out_green: res[1], out_blue: res[2],
                            out_alpha: res[3]};
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire
